>>> src/dmix_pkg.sv
// dmix_pkg: shared constants, types, microcode table and helpers of the
// differential thruster mixer. No dependencies.
package dmix_pkg;

    // Thruster pairs and the index width that addresses them
    localparam int NUM_PAIRS = 2;
    localparam int PAIR_W    = (NUM_PAIRS > 1) ? $clog2(NUM_PAIRS) : 1;

    // Configuration register indexes and reset values
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_PULSE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_PULSE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GEAR   = 2'd2;
    localparam logic [11:0] STOP_PULSE_RST = 12'd1500;
    localparam logic [11:0] END_PULSE_RST  = 12'd2000;
    localparam logic [3:0]  MAX_GEAR_RST   = 4'd4;

    // Stick handling
    localparam logic signed [7:0] DEADBAND = 8'sd5;
    localparam logic signed [7:0] FULL_POS = 8'sd100;
    localparam logic signed [7:0] FULL_NEG = -8'sd100;
    localparam logic [6:0]        FULL     = 7'd100;
    localparam logic [11:0]       PULSE_MAX = 12'd4095;

    // Gear step and direction codes (two-bit signed)
    localparam logic [1:0] STEP_UP   = 2'b01;
    localparam logic [1:0] STEP_DOWN = 2'b11;
    localparam logic [1:0] DIR_STOP  = 2'b00;
    localparam logic [1:0] DIR_FWD   = 2'b01;
    localparam logic [1:0] DIR_REV   = 2'b11;

    // Span divider: 12-bit span by max gear, two quotient bits per cycle
    localparam int DIVD_W    = 12;
    localparam int DVS_W     = 7;
    localparam int DIV_ITER  = DIVD_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_ITER + 1);

    // Division by 100 as a reciprocal multiply, exact for products up to 14e6
    localparam int PROD_W   = 23;
    localparam int RECIP_W  = 24;
    localparam int RECIP_SH = 30;
    localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DVS_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } div_rsp_t;

    // Microcode: step addresses, datapath actions, advance conditions
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] PC_IDLE   = 4'd0;
    localparam logic [PC_W-1:0] PC_MIX    = 4'd1;
    localparam logic [PC_W-1:0] PC_INNER  = 4'd2;
    localparam logic [PC_W-1:0] PC_SPAN   = 4'd3;
    localparam logic [PC_W-1:0] PC_QUOT   = 4'd4;
    localparam logic [PC_W-1:0] PC_RANGE  = 4'd5;
    localparam logic [PC_W-1:0] PC_LSTART = 4'd6;
    localparam logic [PC_W-1:0] PC_LSCALE = 4'd7;
    localparam logic [PC_W-1:0] PC_LPULSE = 4'd8;
    localparam logic [PC_W-1:0] PC_RSTART = 4'd9;
    localparam logic [PC_W-1:0] PC_RSCALE = 4'd10;
    localparam logic [PC_W-1:0] PC_RPULSE = 4'd11;
    localparam logic [PC_W-1:0] PC_EMIT   = 4'd12;

    localparam logic [3:0] ACT_NONE    = 4'd0;
    localparam logic [3:0] ACT_CAPTURE = 4'd1;
    localparam logic [3:0] ACT_MIX     = 4'd2;
    localparam logic [3:0] ACT_INNER   = 4'd3;
    localparam logic [3:0] ACT_SPAN    = 4'd4;
    localparam logic [3:0] ACT_QUOT    = 4'd5;
    localparam logic [3:0] ACT_RANGE   = 4'd6;
    localparam logic [3:0] ACT_LSTART  = 4'd7;
    localparam logic [3:0] ACT_SCALE   = 4'd8;
    localparam logic [3:0] ACT_LPULSE  = 4'd9;
    localparam logic [3:0] ACT_RSTART  = 4'd10;
    localparam logic [3:0] ACT_RPULSE  = 4'd11;
    localparam logic [3:0] ACT_EMIT    = 4'd12;

    localparam logic [1:0] COND_ALWAYS = 2'd0;
    localparam logic [1:0] COND_IN     = 2'd1;
    localparam logic [1:0] COND_DIV    = 2'd2;
    localparam logic [1:0] COND_OUT    = 2'd3;

    // One control word: action fires and the step jumps when cond holds
    typedef struct packed {
        logic [3:0]      act;
        logic [1:0]      cond;
        logic [PC_W-1:0] next_pc;
    } uword_t;

    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            PC_IDLE:   w = '{ACT_CAPTURE, COND_IN,     PC_MIX};
            PC_MIX:    w = '{ACT_MIX,     COND_ALWAYS, PC_INNER};
            PC_INNER:  w = '{ACT_INNER,   COND_ALWAYS, PC_SPAN};
            PC_SPAN:   w = '{ACT_SPAN,    COND_ALWAYS, PC_QUOT};
            PC_QUOT:   w = '{ACT_QUOT,    COND_DIV,    PC_RANGE};
            PC_RANGE:  w = '{ACT_RANGE,   COND_ALWAYS, PC_LSTART};
            PC_LSTART: w = '{ACT_LSTART,  COND_ALWAYS, PC_LSCALE};
            PC_LSCALE: w = '{ACT_SCALE,   COND_ALWAYS, PC_LPULSE};
            PC_LPULSE: w = '{ACT_LPULSE,  COND_ALWAYS, PC_RSTART};
            PC_RSTART: w = '{ACT_RSTART,  COND_ALWAYS, PC_RSCALE};
            PC_RSCALE: w = '{ACT_SCALE,   COND_ALWAYS, PC_RPULSE};
            PC_RPULSE: w = '{ACT_RPULSE,  COND_ALWAYS, PC_EMIT};
            PC_EMIT:   w = '{ACT_EMIT,    COND_OUT,    PC_IDLE};
            default:   w = '{ACT_NONE,    COND_ALWAYS, PC_IDLE};
        endcase
        return w;
    endfunction

    // Clamp a stick value to -100..100
    function automatic logic signed [7:0] clamp100(input logic signed [7:0] v);
        logic signed [7:0] r;
        if (v > FULL_POS)
            r = FULL_POS;
        else if (v < FULL_NEG)
            r = FULL_NEG;
        else
            r = v;
        return r;
    endfunction

    // Saturate a signed pulse width to 0..4095
    function automatic logic [11:0] sat_pulse(input logic signed [17:0] v);
        logic [11:0] r;
        if (v < 18'sd0)
            r = '0;
        else if (v > $signed({6'b0, PULSE_MAX}))
            r = PULSE_MAX;
        else
            r = v[11:0];
        return r;
    endfunction

endpackage

>>> src/dmix_div.sv
// dmix_div: unsigned divider of the thruster mixer, radix 4,
// one pair of quotient bits per cycle. Depends on dmix_pkg.
module dmix_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  dmix_pkg::div_req_t req,
    output dmix_pkg::div_rsp_t rsp
);

    logic [dmix_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [dmix_pkg::DIVD_W-1:0]    quo_reg;
    logic [dmix_pkg::DVS_W-1:0]     rem_reg;
    logic [dmix_pkg::DVS_W-1:0]     dvs_reg;

    logic [dmix_pkg::DVS_W:0]   t1;
    logic [dmix_pkg::DVS_W:0]   t2;
    logic [dmix_pkg::DVS_W-1:0] r1;
    logic [dmix_pkg::DVS_W-1:0] r2;
    logic                       b1;
    logic                       b2;

    // Two restoring steps; the remainder always stays below the divisor
    always_comb
    begin
        t1 = {rem_reg, quo_reg[dmix_pkg::DIVD_W-1]};
        b1 = (t1 >= {1'b0, dvs_reg});
        r1 = b1 ? dmix_pkg::DVS_W'(t1 - {1'b0, dvs_reg}) : t1[dmix_pkg::DVS_W-1:0];
        t2 = {r1, quo_reg[dmix_pkg::DIVD_W-2]};
        b2 = (t2 >= {1'b0, dvs_reg});
        r2 = b2 ? dmix_pkg::DVS_W'(t2 - {1'b0, dvs_reg}) : t2[dmix_pkg::DVS_W-1:0];
    end

    // Iteration counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (req.start)
        begin
            cnt_reg <= dmix_pkg::DIV_CNT_W'(dmix_pkg::DIV_ITER);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Quotient shifts in from the bottom as the dividend shifts out the top
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[dmix_pkg::DIVD_W-3:0], b1, b2};
            rem_reg <= r2;
        end
    end

    assign rsp.done     = (cnt_reg == '0);
    assign rsp.quotient = quo_reg;

endmodule

>>> src/differential_thruster_mixer_unit.sv
// Differential thruster mixer: joystick command to per-motor direction,
// power and ESC pulse width, with a gear level kept per thruster pair.
// One command at a time: a new command is taken only at the idle step, after
// the previous result is emitted; the sequencer waits at its quotient step on
// the span divider. A stalled result holds the sequencer at its emit step.
// Reset (async, active low): pulse settings 1500/2000 us, max gear 4,
// all gear levels 0, sequencer idle, no result pending.
module differential_thruster_mixer_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [dmix_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [11:0]                     cfg_data,
    // command input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [23:0]                     s_tdata,  // stick_x, stick_y, gear_step
    input  logic                            s_tuser,  // pair_select
    // result output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [47:0]                     m_tdata,  // left_dir, left_power, right_dir,
                                                      // right_power, gear_now,
                                                      // left_pulse_us, right_pulse_us
    output logic                            m_tuser   // pair_echo
);

    // Configuration registers
    logic [11:0] stop_reg;
    logic [11:0] end_reg;
    logic [3:0]  max_gear_reg;

    // Sequencer
    logic [dmix_pkg::PC_W-1:0] pc_reg;
    dmix_pkg::uword_t          uw;
    logic                      fire;

    // Datapath registers
    logic                          sel_reg;
    logic signed [7:0]             x_reg;
    logic signed [7:0]             y_reg;
    logic [1:0]                    step_reg;
    logic [3:0]                    gear_level_reg [dmix_pkg::NUM_PAIRS];
    logic [3:0]                    gear_reg;
    logic [1:0]                    d1_reg;
    logic [1:0]                    d2_reg;
    logic [6:0]                    p1_reg;
    logic [6:0]                    p2_reg;
    logic                          inner_l_reg;
    logic                          inner_r_reg;
    logic                          span_neg_reg;
    logic signed [12:0]            q_reg;
    logic signed [16:0]            range_reg;
    logic [dmix_pkg::PROD_W-1:0]   prod_reg;
    logic [15:0]                   scaled_reg;
    logic [11:0]                   lpulse_reg;
    logic [11:0]                   rpulse_reg;
    logic                          m_tvalid_reg;
    logic [47:0]                   m_tdata_reg;
    logic                          m_tuser_reg;

    // Combinational datapath
    logic [dmix_pkg::PAIR_W-1:0] pidx;
    logic [3:0]                  g_cur;
    logic [3:0]                  g_new;
    logic [6:0]                  ax;
    logic [6:0]                  ay;
    logic                        y_move;
    logic                        y_fwd;
    logic                        x_right;
    logic                        x_left;
    logic signed [12:0]          span;
    logic [11:0]                 span_abs;
    logic [6:0]                  max_div;
    logic signed [17:0]          range_prod;
    logic [15:0]                 range_abs;
    logic [15:0]                 mul_a;
    logic [6:0]                  mul_b;
    logic [22:0]                 mul_p;
    logic [dmix_pkg::PROD_W+dmix_pkg::RECIP_W-1:0] recip_p;
    logic [15:0]                 recip_q;
    logic                        pulse_neg;
    logic signed [17:0]          stop_ext;
    logic signed [17:0]          off_ext;
    logic signed [17:0]          pulse_sum;
    logic [11:0]                 pulse_sat;
    dmix_pkg::div_req_t          div_req;
    dmix_pkg::div_rsp_t          div_rsp;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_reg     <= dmix_pkg::STOP_PULSE_RST;
            end_reg      <= dmix_pkg::END_PULSE_RST;
            max_gear_reg <= dmix_pkg::MAX_GEAR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dmix_pkg::CFG_STOP_PULSE: stop_reg     <= cfg_data;
                dmix_pkg::CFG_END_PULSE:  end_reg      <= cfg_data;
                dmix_pkg::CFG_MAX_GEAR:   max_gear_reg <= cfg_data[3:0];
                default:                  ;
            endcase
        end
    end

    // Control word fetch and advance condition
    assign uw = dmix_pkg::ucode(pc_reg);

    always_comb
    begin
        case (uw.cond)
            dmix_pkg::COND_ALWAYS: fire = 1'b1;
            dmix_pkg::COND_IN:     fire = s_tvalid;
            dmix_pkg::COND_DIV:    fire = div_rsp.done;
            dmix_pkg::COND_OUT:    fire = !m_tvalid_reg || m_tready;
            default:               fire = 1'b1;
        endcase
    end

    assign s_tready = (uw.cond == dmix_pkg::COND_IN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= dmix_pkg::PC_IDLE;
        else if (fire)
            pc_reg <= uw.next_pc;
    end

    // Stick decode
    assign ax      = x_reg[7] ? 7'(-x_reg) : x_reg[6:0];
    assign ay      = y_reg[7] ? 7'(-y_reg) : y_reg[6:0];
    assign y_fwd   = (y_reg > dmix_pkg::DEADBAND);
    assign y_move  = y_fwd || (y_reg < -dmix_pkg::DEADBAND);
    assign x_right = (x_reg > dmix_pkg::DEADBAND);
    assign x_left  = (x_reg < -dmix_pkg::DEADBAND);

    // Gear update for the selected pair
    assign pidx  = (dmix_pkg::NUM_PAIRS > 1) ? dmix_pkg::PAIR_W'(sel_reg) : '0;
    assign g_cur = gear_level_reg[pidx];

    always_comb
    begin
        g_new = g_cur;
        if (step_reg == dmix_pkg::STEP_UP && g_cur < max_gear_reg)
            g_new = g_cur + 4'd1;
        else if (step_reg == dmix_pkg::STEP_DOWN && g_cur != 4'd0)
            g_new = g_cur - 4'd1;
    end

    // Pulse span and per-gear range
    assign span       = $signed({1'b0, end_reg}) - $signed({1'b0, stop_reg});
    assign span_abs   = span[12] ? 12'(-span) : span[11:0];
    assign max_div    = (max_gear_reg == 4'd0) ? 7'd1 : {3'b0, max_gear_reg};
    assign range_prod = 18'(q_reg) * 18'($signed({1'b0, gear_reg}));
    assign range_abs  = range_reg[16] ? 16'(-range_reg) : range_reg[15:0];

    // Shared multiplier: inner-motor product or range times power
    always_comb
    begin
        case (uw.act)
            dmix_pkg::ACT_MIX:
            begin
                mul_a = 16'(dmix_pkg::FULL - ax);
                mul_b = ay;
            end
            dmix_pkg::ACT_RSTART:
            begin
                mul_a = range_abs;
                mul_b = p2_reg;
            end
            default:
            begin
                mul_a = range_abs;
                mul_b = p1_reg;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Registered product divided by 100 through the reciprocal
    assign recip_p = prod_reg * dmix_pkg::RECIP_100;
    assign recip_q = recip_p[dmix_pkg::RECIP_SH +: 16];

    // Span divider request
    always_comb
    begin
        div_req.start    = (uw.act == dmix_pkg::ACT_SPAN);
        div_req.dividend = span_abs;
        div_req.divisor  = max_div;
    end

    dmix_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Pulse: stop plus or minus the scaled offset, then saturate
    always_comb
    begin
        if (uw.act == dmix_pkg::ACT_RPULSE)
            pulse_neg = range_reg[16] ^ (d2_reg == dmix_pkg::DIR_REV);
        else
            pulse_neg = range_reg[16] ^ (d1_reg == dmix_pkg::DIR_REV);
        stop_ext  = $signed({6'b0, stop_reg});
        off_ext   = $signed({2'b0, scaled_reg});
        pulse_sum = pulse_neg ? (stop_ext - off_ext) : (stop_ext + off_ext);
        pulse_sat = dmix_pkg::sat_pulse(pulse_sum);
    end

    // Gear levels per pair
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < dmix_pkg::NUM_PAIRS; i++)
                gear_level_reg[i] <= '0;
        end
        else if (fire && uw.act == dmix_pkg::ACT_MIX)
        begin
            gear_level_reg[pidx] <= g_new;
        end
    end

    // Datapath actions, one per control word
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            case (uw.act)
                dmix_pkg::ACT_CAPTURE:
                begin
                    sel_reg  <= s_tuser;
                    x_reg    <= dmix_pkg::clamp100($signed(s_tdata[7:0]));
                    y_reg    <= dmix_pkg::clamp100($signed(s_tdata[15:8]));
                    step_reg <= s_tdata[17:16];
                end
                dmix_pkg::ACT_MIX:
                begin
                    gear_reg <= g_new;
                    prod_reg <= mul_p;
                    if (y_move)
                    begin
                        d1_reg      <= y_fwd ? dmix_pkg::DIR_FWD : dmix_pkg::DIR_REV;
                        d2_reg      <= y_fwd ? dmix_pkg::DIR_FWD : dmix_pkg::DIR_REV;
                        p1_reg      <= ay;
                        p2_reg      <= ay;
                        inner_l_reg <= x_left;
                        inner_r_reg <= x_right;
                    end
                    else
                    begin
                        inner_l_reg <= 1'b0;
                        inner_r_reg <= 1'b0;
                        if (x_right)
                        begin
                            d1_reg <= dmix_pkg::DIR_FWD;
                            d2_reg <= dmix_pkg::DIR_REV;
                            p1_reg <= ax;
                            p2_reg <= ax;
                        end
                        else if (x_left)
                        begin
                            d1_reg <= dmix_pkg::DIR_REV;
                            d2_reg <= dmix_pkg::DIR_FWD;
                            p1_reg <= ax;
                            p2_reg <= ax;
                        end
                        else
                        begin
                            d1_reg <= dmix_pkg::DIR_STOP;
                            d2_reg <= dmix_pkg::DIR_STOP;
                            p1_reg <= '0;
                            p2_reg <= '0;
                        end
                    end
                end
                dmix_pkg::ACT_INNER:
                begin
                    // scaled power for the motor on the inside of the turn
                    if (inner_l_reg)
                        p1_reg <= recip_q[6:0];
                    if (inner_r_reg)
                        p2_reg <= recip_q[6:0];
                end
                dmix_pkg::ACT_SPAN:
                begin
                    span_neg_reg <= span[12];
                end
                dmix_pkg::ACT_QUOT:
                begin
                    // truncating signed quotient of span by max gear
                    if (span_neg_reg)
                        q_reg <= -$signed({1'b0, div_rsp.quotient[11:0]});
                    else
                        q_reg <= $signed({1'b0, div_rsp.quotient[11:0]});
                end
                dmix_pkg::ACT_RANGE:
                begin
                    range_reg <= range_prod[16:0];
                end
                dmix_pkg::ACT_LSTART,
                dmix_pkg::ACT_RSTART:
                begin
                    prod_reg <= mul_p;
                end
                dmix_pkg::ACT_SCALE:
                begin
                    scaled_reg <= recip_q;
                end
                dmix_pkg::ACT_LPULSE:
                begin
                    lpulse_reg <= pulse_sat;
                end
                dmix_pkg::ACT_RPULSE:
                begin
                    rpulse_reg <= pulse_sat;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (fire && uw.act == dmix_pkg::ACT_EMIT)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && uw.act == dmix_pkg::ACT_EMIT)
        begin
            m_tuser_reg <= sel_reg;
            m_tdata_reg <= {2'b00, rpulse_reg, lpulse_reg, gear_reg,
                            p2_reg, d2_reg, p1_reg, d1_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> dv/tb_top.sv
// tb_top: self-checking bench for differential_thruster_mixer_unit. Drives joystick
// commands on the slave stream, predicts each mix result and compares it per field.
// Depends on dmix_pkg and the mixer RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Local names for the package codes used in the tables
    localparam logic [1:0] STEP_UP   = dmix_pkg::STEP_UP;
    localparam logic [1:0] STEP_DOWN = dmix_pkg::STEP_DOWN;
    localparam logic [1:0] DIR_STOP  = dmix_pkg::DIR_STOP;
    localparam logic [1:0] DIR_FWD   = dmix_pkg::DIR_FWD;
    localparam logic [1:0] DIR_REV   = dmix_pkg::DIR_REV;

    // Gear step codes not named in the package; minus two keeps the gear as well
    localparam logic [1:0] STEP_NONE = 2'b00;
    localparam logic [1:0] STEP_HOLD = 2'b10;
    localparam logic [dmix_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int MIX_DEADBAND = 5;
    localparam int MIX_FULL     = 100;
    localparam int PULSE_TOP    = 4095;
    localparam int PHASE_ITEMS  = 240;
    localparam int NUM_PHASES   = 8;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic       pair;
        logic [7:0] sx;
        logic [7:0] sy;
        logic [1:0] step;
    } cmd_t;

    typedef struct packed {
        logic        pair;
        logic [1:0]  ldir;
        logic [6:0]  lpow;
        logic [1:0]  rdir;
        logic [6:0]  rpow;
        logic [3:0]  gear;
        logic [11:0] lpulse;
        logic [11:0] rpulse;
    } thrust_t;

    typedef struct packed {
        logic    fixed;
        cmd_t    cmd;
        thrust_t want;
    } dir_row_t;

    typedef struct packed {
        logic [11:0] stop_us;
        logic [11:0] top_us;
        logic [3:0]  top_gear;
        logic        climb;
    } pulse_set_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [dmix_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [11:0]                    cfg_data  = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [23:0]                    s_tdata   = '0;
    logic                           s_tuser   = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [47:0]                    m_tdata;
    logic                           m_tuser;

    // Mirror of the block's registers and per-pair gear
    logic [11:0] stop_reg     = dmix_pkg::STOP_PULSE_RST;
    logic [11:0] top_reg      = dmix_pkg::END_PULSE_RST;
    logic [3:0]  max_gear_reg = dmix_pkg::MAX_GEAR_RST;
    logic [3:0]  gear_lvl [dmix_pkg::NUM_PAIRS];

    thrust_t pending_thrust [$];
    int      errors     = 0;
    int      items_sent = 0;
    int      stall_cnt  = 0;
    int      tx_idle_pct = 9;
    int      rx_idle_pct = 86;

    // Directed commands; fixed rows carry an expectation read straight off the spec
    // with the reset pulse settings (125 us per gear step)
    dir_row_t dir_rows [18] = '{
        '{1'b1, '{1'b0, 8'd0, 8'd0, STEP_NONE},
          '{1'b0, DIR_STOP, 7'd0, DIR_STOP, 7'd0, 4'd0, 12'd1500, 12'd1500}},
        '{1'b1, '{1'b0, 8'd0, 8'sd127, STEP_UP},
          '{1'b0, DIR_FWD, 7'd100, DIR_FWD, 7'd100, 4'd1, 12'd1625, 12'd1625}},
        '{1'b1, '{1'b0, 8'd0, 8'h80, STEP_UP},
          '{1'b0, DIR_REV, 7'd100, DIR_REV, 7'd100, 4'd2, 12'd1250, 12'd1250}},
        '{1'b1, '{1'b1, 8'sd127, 8'd0, STEP_NONE},
          '{1'b1, DIR_FWD, 7'd100, DIR_REV, 7'd100, 4'd0, 12'd1500, 12'd1500}},
        '{1'b1, '{1'b1, 8'h80, 8'd0, STEP_DOWN},
          '{1'b1, DIR_REV, 7'd100, DIR_FWD, 7'd100, 4'd0, 12'd1500, 12'd1500}},
        '{1'b1, '{1'b0, 8'sd5, -8'sd5, STEP_HOLD},
          '{1'b0, DIR_STOP, 7'd0, DIR_STOP, 7'd0, 4'd2, 12'd1500, 12'd1500}},
        '{1'b0, '{1'b0, 8'sd6, 8'sd6, STEP_NONE}, '0},
        '{1'b0, '{1'b0, -8'sd6, -8'sd6, STEP_NONE}, '0},
        '{1'b0, '{1'b0, 8'sd50, 8'sd100, STEP_UP}, '0},
        '{1'b0, '{1'b0, -8'sd100, 8'sd50, STEP_UP}, '0},
        '{1'b1, '{1'b0, 8'd0, 8'sd100, STEP_UP},
          '{1'b0, DIR_FWD, 7'd100, DIR_FWD, 7'd100, 4'd4, 12'd2000, 12'd2000}},
        '{1'b0, '{1'b1, -8'sd5, -8'sd5, STEP_UP}, '0},
        '{1'b0, '{1'b0, -8'sd6, 8'd0, STEP_DOWN}, '0},
        '{1'b0, '{1'b0, 8'sd6, -8'sd100, STEP_NONE}, '0},
        '{1'b0, '{1'b1, 8'sd127, 8'sd127, STEP_UP}, '0},
        '{1'b0, '{1'b0, -8'sd101, -8'sd101, STEP_HOLD}, '0},
        '{1'b0, '{1'b1, 8'sd101, 8'sd6, STEP_DOWN}, '0},
        '{1'b1, '{1'b0, 8'd0, -8'sd100, STEP_DOWN},
          '{1'b0, DIR_REV, 7'd100, DIR_REV, 7'd100, 4'd2, 12'd1250, 12'd1250}}
    };

    // Pulse settings per phase: reset values, full range, saturation, zero top gear,
    // end below stop, equal stop and end; the last one is drawn at random
    pulse_set_t pulse_sets [NUM_PHASES] = '{
        '{12'd1500, 12'd2000, 4'd4,  1'b1},
        '{12'd500,  12'd2500, 4'd15, 1'b1},
        '{12'd0,    12'd4095, 4'd15, 1'b1},
        '{12'd1500, 12'd2000, 4'd0,  1'b0},
        '{12'd4095, 12'd0,    4'd7,  1'b0},
        '{12'd2500, 12'd500,  4'd1,  1'b1},
        '{12'd4095, 12'd4095, 4'd2,  1'b0},
        '{12'd1500, 12'd2000, 4'd4,  1'b1}
    };

    differential_thruster_mixer_unit DUT (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        foreach (gear_lvl[i])
            gear_lvl[i] = '0;
    end

    function automatic int clamp_stick(input logic [7:0] v);
        int s;
        s = int'($signed(v));
        if (s > MIX_FULL)
            s = MIX_FULL;
        else if (s < -MIX_FULL)
            s = -MIX_FULL;
        return s;
    endfunction

    function automatic logic [1:0] dir_code(input int d);
        if (d == 1)
            return DIR_FWD;
        else if (d == -1)
            return DIR_REV;
        return DIR_STOP;
    endfunction

    // ESC pulse: stop +/- ((span / top gear) * gear) * power / 100, saturated
    function automatic logic [11:0] esc_pulse(input int d, input int pw, input logic [3:0] g);
        int stop_v, span, dv, rng, us;
        stop_v = int'(stop_reg);
        span   = int'(top_reg) - stop_v;
        dv     = (max_gear_reg == 4'd0) ? 1 : int'(max_gear_reg);
        rng    = (span / dv) * int'(g);
        us     = stop_v;
        if (d == 1)
            us = stop_v + (rng * pw) / MIX_FULL;
        else if (d == -1)
            us = stop_v - (rng * pw) / MIX_FULL;
        if (us < 0)
            us = 0;
        if (us > PULSE_TOP)
            us = PULSE_TOP;
        return 12'(us);
    endfunction

    // Gear update and stick mixing for one command; updates the gear mirror
    function automatic thrust_t predict_thrust(input cmd_t c);
        thrust_t r;
        int x, y, st, ay, d1, d2, p1, p2;
        int sel;
        logic [3:0] g;
        sel = int'(c.pair) % dmix_pkg::NUM_PAIRS;
        x   = clamp_stick(c.sx);
        y   = clamp_stick(c.sy);
        st  = int'($signed(c.step));
        g   = gear_lvl[sel];
        if (st == 1 && g < max_gear_reg)
            g = g + 4'd1;
        if (st == -1 && g > 4'd0)
            g = g - 4'd1;
        gear_lvl[sel] = g;
        d1 = 0;
        d2 = 0;
        p1 = 0;
        p2 = 0;
        if (y > MIX_DEADBAND || y < -MIX_DEADBAND)
        begin
            // drive: the motor on the inside of the turn is scaled down
            ay = (y > 0) ? y : -y;
            d1 = (y > 0) ? 1 : -1;
            d2 = d1;
            p1 = ay;
            p2 = ay;
            if (x > MIX_DEADBAND)
                p2 = ((MIX_FULL - x) * ay) / MIX_FULL;
            else if (x < -MIX_DEADBAND)
                p1 = ((MIX_FULL + x) * ay) / MIX_FULL;
        end
        else if (x > MIX_DEADBAND)
        begin
            d1 = 1;
            d2 = -1;
            p1 = x;
            p2 = x;
        end
        else if (x < -MIX_DEADBAND)
        begin
            d1 = -1;
            d2 = 1;
            p1 = -x;
            p2 = -x;
        end
        r.pair   = c.pair;
        r.ldir   = dir_code(d1);
        r.lpow   = 7'(p1);
        r.rdir   = dir_code(d2);
        r.rpow   = 7'(p2);
        r.gear   = g;
        r.lpulse = esc_pulse(d1, p1, g);
        r.rpulse = esc_pulse(d2, p2, g);
        return r;
    endfunction

    // Mostly in-range sticks, some around the deadband, some full 8-bit
    function automatic logic [7:0] rand_stick();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(0, 255));
            1:       return 8'(int'($urandom_range(0, 14)) - 7);
            default: return 8'(int'($urandom_range(0, 200)) - 100);
        endcase
    endfunction

    function automatic cmd_t rand_cmd(input logic climb);
        cmd_t c;
        int r;
        c.pair = 1'($urandom_range(0, 1));
        c.sx   = rand_stick();
        c.sy   = rand_stick();
        r      = $urandom_range(0, 9);
        if (r < (climb ? 5 : 2))
            c.step = STEP_UP;
        else if (r < 7)
            c.step = STEP_DOWN;
        else if (r < 9)
            c.step = STEP_NONE;
        else
            c.step = STEP_HOLD;
        return c;
    endfunction

    // Drop valid and wait until every expected result has been taken
    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_thrust.size() != 0);
    endtask

    task automatic write_reg(input logic [dmix_pkg::CFG_IDX_W-1:0] idx,
                             input logic [11:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            dmix_pkg::CFG_STOP_PULSE: stop_reg = val;
            dmix_pkg::CFG_END_PULSE:  top_reg = val;
            dmix_pkg::CFG_MAX_GEAR:   max_gear_reg = val[3:0];
            default:                  ;
        endcase
    endtask

    // One command transaction; the expectation is queued at acceptance
    task automatic send_cmd(input cmd_t c, input logic fixed, input thrust_t want,
                            input logic hold_off);
        thrust_t model;
        if (items_sent < 650)
        begin
            tx_idle_pct = 9;
            rx_idle_pct = 86;
        end
        else if (items_sent < 1300)
        begin
            tx_idle_pct = 86;
            rx_idle_pct = 9;
        end
        else
        begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        if (hold_off)
            settle();
        else
        begin
            while ($urandom_range(0, 99) < tx_idle_pct)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, c.step, c.sy, c.sx};
        s_tuser  <= c.pair;
        do
            @(posedge clk);
        while (!s_tready);
        model = predict_thrust(c);
        pending_thrust.push_back(fixed ? want : model);
        items_sent++;
    endtask

    task automatic cmp_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Result side: random back-pressure
    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

    // Result checker
    always @(posedge clk)
    begin
        thrust_t got;
        thrust_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.pair   = m_tuser;
            got.ldir   = m_tdata[1:0];
            got.lpow   = m_tdata[8:2];
            got.rdir   = m_tdata[10:9];
            got.rpow   = m_tdata[17:11];
            got.gear   = m_tdata[21:18];
            got.lpulse = m_tdata[33:22];
            got.rpulse = m_tdata[45:34];
            if (pending_thrust.size() == 0)
            begin
                $error("result transaction with no command outstanding");
                errors++;
            end
            else
            begin
                want = pending_thrust.pop_front();
                cmp_field("pair_echo", want.pair, got.pair);
                cmp_field("left_dir", want.ldir, got.ldir);
                cmp_field("left_power", want.lpow, got.lpow);
                cmp_field("right_dir", want.rdir, got.rdir);
                cmp_field("right_power", want.rpow, got.rpow);
                cmp_field("gear_now", want.gear, got.gear);
                cmp_field("left_pulse_us", want.lpulse, got.lpulse);
                cmp_field("right_pulse_us", want.rpulse, got.rpulse);
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cnt <= 0;
        else if (stall_cnt >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            stall_cnt <= stall_cnt + 1;
    end

    // Main sequence
    initial
    begin
        pulse_set_t ps;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_cmd(dir_rows[i].cmd, dir_rows[i].fixed, dir_rows[i].want, 1'b0);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            ps = pulse_sets[ph];
            if (ph == NUM_PHASES - 1)
            begin
                ps.stop_us  = 12'($urandom_range(500, 2500));
                ps.top_us   = 12'($urandom_range(500, 2500));
                ps.top_gear = 4'($urandom_range(1, 15));
            end
            settle();
            write_reg(dmix_pkg::CFG_STOP_PULSE, ps.stop_us);
            write_reg(dmix_pkg::CFG_END_PULSE, ps.top_us);
            // upper data bits of the gear register are don't-care
            write_reg(dmix_pkg::CFG_MAX_GEAR, {8'($urandom_range(0, 255)), ps.top_gear});
            write_reg(CFG_UNUSED, 12'($urandom_range(0, 4095)));
            cfg_we <= 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_cmd(rand_cmd(ps.climb), 1'b0, '0, $urandom_range(0, 59) == 0);
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
src/dmix_pkg.sv
src/dmix_div.sv
src/differential_thruster_mixer_unit.sv
dv/tb_top.sv
